// File: rtl/assert_macros.svh
// Shared assertion macros. Every macro expects signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/plas_pkg.sv
package plas_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam int NOW_W   = 32;
    localparam int DEB_W   = 16;
    localparam int HOLD_W  = 32;
    localparam int PULSE_W = 12;
    localparam int CODE_W  = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 3'd0,
        CFG_LONG_PRESS    = 3'd1,
        CFG_ACTIVE_HOLD   = 3'd2,
        CFG_REST_HOLD     = 3'd3,
        CFG_A_ACTIVE_PLS  = 3'd4,
        CFG_A_REST_PLS    = 3'd5,
        CFG_B_ACTIVE_PLS  = 3'd6,
        CFG_B_REST_PLS    = 3'd7
    } cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST     = 16'd50;
    localparam logic [HOLD_W-1:0]  LONG_PRESS_RST   = 32'd5000;
    localparam logic [HOLD_W-1:0]  ACTIVE_HOLD_RST  = 32'd1000;
    localparam logic [HOLD_W-1:0]  REST_HOLD_RST    = 32'd1000;
    localparam logic [PULSE_W-1:0] A_ACTIVE_PLS_RST = 12'd1240;
    localparam logic [PULSE_W-1:0] A_REST_PLS_RST   = 12'd500;
    localparam logic [PULSE_W-1:0] B_ACTIVE_PLS_RST = 12'd2000;
    localparam logic [PULSE_W-1:0] B_REST_PLS_RST   = 12'd1600;

    // Actuator phase, one-hot inside the design.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_ACTIVE = 3'b010,
        PH_REST   = 3'b100
    } phase_t;

    // Phase codes as they appear on the result item.
    localparam logic [CODE_W-1:0] PH_CODE_IDLE   = 2'd0;
    localparam logic [CODE_W-1:0] PH_CODE_ACTIVE = 2'd1;
    localparam logic [CODE_W-1:0] PH_CODE_REST   = 2'd2;

    // Sequence start codes.
    localparam logic [CODE_W-1:0] START_NONE = 2'd0;
    localparam logic [CODE_W-1:0] START_A    = 2'd1;
    localparam logic [CODE_W-1:0] START_B    = 2'd2;

    // Button event from the debouncer to the sequencing logic.
    typedef struct packed {
        logic release_evt;   // debounced release that follows a debounced press
        logic is_long;       // the measured press reached the long press time
        logic level;         // debounced level after this poll
    } btn_evt_t;

    function automatic logic [CODE_W-1:0] phase_code(phase_t p);
        logic [CODE_W-1:0] c;
        unique case (p)
            PH_ACTIVE: c = PH_CODE_ACTIVE;
            PH_REST:   c = PH_CODE_REST;
            PH_IDLE:   c = PH_CODE_IDLE;
            default:   c = PH_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/plas_debounce.sv
// Button debouncer and press length measurement.
module plas_debounce #(
    parameter int TIME_WIDTH = plas_pkg::TIME_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        level,
    input  logic [TIME_WIDTH-1:0]       now_t,
    input  logic [plas_pkg::DEB_W-1:0]  debounce_ms,
    input  logic [plas_pkg::HOLD_W-1:0] long_press_ms,
    output plas_pkg::btn_evt_t          evt
);

    localparam int CW = (TIME_WIDTH > plas_pkg::HOLD_W) ? TIME_WIDTH : plas_pkg::HOLD_W;

    logic                  raw_last_reg, raw_last_next;
    logic                  level_stable_reg, level_stable_next;
    logic                  press_pending_reg, press_pending_next;
    logic [TIME_WIDTH-1:0] raw_change_time_reg, raw_change_time_next;
    logic [TIME_WIDTH-1:0] press_start_time_reg, press_start_time_next;

    logic [TIME_WIDTH-1:0] since_change;
    logic [TIME_WIDTH-1:0] press_len;
    logic                  accept;

    always_comb
    begin
        raw_last_next        = level;
        raw_change_time_next = (level != raw_last_reg) ? now_t : raw_change_time_reg;
        since_change         = now_t - raw_change_time_next;
        press_len            = now_t - press_start_time_reg;

        accept = (level != level_stable_reg) &&
                 (CW'(since_change) >= CW'(debounce_ms));

        level_stable_next     = accept ? level : level_stable_reg;
        press_start_time_next = (accept && !level) ? now_t : press_start_time_reg;
        press_pending_next    = accept ? !level : press_pending_reg;

        evt.release_evt = accept && level && press_pending_reg;
        evt.is_long     = CW'(press_len) >= CW'(long_press_ms);
        evt.level       = level_stable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_last_reg         <= 1'b1;
            level_stable_reg     <= 1'b1;
            press_pending_reg    <= 1'b0;
            raw_change_time_reg  <= '0;
            press_start_time_reg <= '0;
        end
        else if (en)
        begin
            raw_last_reg         <= raw_last_next;
            level_stable_reg     <= level_stable_next;
            press_pending_reg    <= press_pending_next;
            raw_change_time_reg  <= raw_change_time_next;
            press_start_time_reg <= press_start_time_next;
        end
    end

endmodule

// File: rtl/plas_seq.sv
// Phase sequencer of one actuator: idle, hold active, hold rest, idle.
module plas_seq #(
    parameter int TIME_WIDTH = plas_pkg::TIME_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         start,
    input  logic [TIME_WIDTH-1:0]        now_t,
    input  logic [plas_pkg::HOLD_W-1:0]  active_hold_ms,
    input  logic [plas_pkg::HOLD_W-1:0]  rest_hold_ms,
    input  logic [plas_pkg::PULSE_W-1:0] active_pulse_us,
    input  logic [plas_pkg::PULSE_W-1:0] rest_pulse_us,
    output plas_pkg::phase_t             phase_next,
    output logic [plas_pkg::PULSE_W-1:0] pulse_us,
    output logic                         busy
);

    localparam int CW = (TIME_WIDTH > plas_pkg::HOLD_W) ? TIME_WIDTH : plas_pkg::HOLD_W;

    plas_pkg::phase_t      phase_reg;
    plas_pkg::phase_t      phase_in;
    logic [TIME_WIDTH-1:0] start_time_reg, start_time_next;
    logic [TIME_WIDTH-1:0] start_in;
    logic [TIME_WIDTH-1:0] held_t;
    logic [CW-1:0]         held;

    always_comb
    begin
        // A start enters the active phase first; the hold check may then leave it
        // at once when the hold time is zero.
        phase_in        = start ? plas_pkg::PH_ACTIVE : phase_reg;
        start_in        = start ? now_t : start_time_reg;
        // The elapsed time wraps at the timestamp width before it is compared.
        held_t          = now_t - start_in;
        held            = CW'(held_t);
        phase_next      = phase_in;
        start_time_next = start_in;
        unique case (phase_in)
            plas_pkg::PH_ACTIVE:
            begin
                if (held >= CW'(active_hold_ms))
                begin
                    phase_next      = plas_pkg::PH_REST;
                    start_time_next = now_t;
                end
            end
            plas_pkg::PH_REST:
            begin
                if (held >= CW'(rest_hold_ms))
                begin
                    phase_next = plas_pkg::PH_IDLE;
                end
            end
            plas_pkg::PH_IDLE: ;
            default: ;
        endcase

        pulse_us = (phase_next == plas_pkg::PH_ACTIVE) ? active_pulse_us : rest_pulse_us;
        busy     = (phase_reg != plas_pkg::PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= plas_pkg::PH_IDLE;
            start_time_reg <= '0;
        end
        else if (en)
        begin
            phase_reg      <= phase_next;
            start_time_reg <= start_time_next;
        end
    end

endmodule

// File: rtl/press_length_actuator_sequencer_unit.sv
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+------------------------------------
// poll      | in        | s_axis_tvalid/s_axis_tready  | s_axis_tdata: button_level, now_ms
// result    | out       | m_axis_tvalid/m_axis_tready  | m_axis_tdata: pulses, phases, level
// config    | in        | cfg_we (no wait)             | cfg_addr, cfg_data
//
// Each poll item is captured in the input register at the edge that accepts it and is
// stepped through the debounce and phase logic into the result register at the first
// edge where that register is empty or being taken; the result is offered from there.
// A new item is accepted every cycle while the result side is not stalled; the throughput
// of one item per cycle is set by the single state update in the debounce and phase logic.
// Reset is asynchronous and active low; it clears both stages, the button and phase
// state, and loads the configuration registers with their power-up values.
// When the result is not taken, the result register holds and the input register
// fills; s_axis_tready falls only when both stages hold an item.
module press_length_actuator_sequencer_unit #(
    parameter int TIME_WIDTH = plas_pkg::TIME_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] button_level, [32:1] now_ms, [39:33] zero
    input  logic [plas_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [11:0] pulse_a_us, [23:12] pulse_b_us, [25:24] phase_a, [27:26] phase_b,
    // [28] debounced_level, [30:29] sequence_started, [31] zero
    output logic [plas_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [plas_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [plas_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = (TIME_WIDTH > plas_pkg::NOW_W) ? TIME_WIDTH : plas_pkg::NOW_W;

    // Configuration registers.
    logic [plas_pkg::DEB_W-1:0]   debounce_ms_reg;
    logic [plas_pkg::HOLD_W-1:0]  long_press_ms_reg;
    logic [plas_pkg::HOLD_W-1:0]  active_hold_ms_reg;
    logic [plas_pkg::HOLD_W-1:0]  rest_hold_ms_reg;
    logic [plas_pkg::PULSE_W-1:0] a_active_pulse_reg;
    logic [plas_pkg::PULSE_W-1:0] a_rest_pulse_reg;
    logic [plas_pkg::PULSE_W-1:0] b_active_pulse_reg;
    logic [plas_pkg::PULSE_W-1:0] b_rest_pulse_reg;

    // Input stage.
    logic                       in_valid_reg, in_valid_next;
    logic                       in_level_reg;
    logic [plas_pkg::NOW_W-1:0] in_now_reg;

    // Result stage.
    logic                             out_valid_reg, out_valid_next;
    logic [plas_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                  advance;
    logic                  step;
    logic                  s_accept;
    logic [CW-1:0]         now_ext;
    logic [TIME_WIDTH-1:0] now_t;

    plas_pkg::btn_evt_t           evt;
    logic                         start_a, start_b;
    logic                         busy_a, busy_b;
    plas_pkg::phase_t             phase_a, phase_b;
    logic [plas_pkg::PULSE_W-1:0] pulse_a, pulse_b;
    logic [plas_pkg::CODE_W-1:0]  started;

    // The result register moves on when it is empty or being taken; the input
    // register can then hand its item over in the same cycle.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign step          = in_valid_reg && advance;

    // The timestamp is kept modulo two to the TIME_WIDTH.
    assign now_ext = CW'(in_now_reg);
    assign now_t   = now_ext[TIME_WIDTH-1:0];

    plas_debounce #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_debounce (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (step),
        .level         (in_level_reg),
        .now_t         (now_t),
        .debounce_ms   (debounce_ms_reg),
        .long_press_ms (long_press_ms_reg),
        .evt           (evt)
    );

    // A release only starts a sequence when both actuators are idle; a long press
    // selects actuator B, a short one actuator A.
    always_comb
    begin
        start_a = evt.release_evt && !busy_a && !busy_b && !evt.is_long;
        start_b = evt.release_evt && !busy_a && !busy_b && evt.is_long;
        priority if (start_b)
        begin
            started = plas_pkg::START_B;
        end
        else if (start_a)
        begin
            started = plas_pkg::START_A;
        end
        else
        begin
            started = plas_pkg::START_NONE;
        end
    end

    plas_seq #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_seq_a (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (step),
        .start           (start_a),
        .now_t           (now_t),
        .active_hold_ms  (active_hold_ms_reg),
        .rest_hold_ms    (rest_hold_ms_reg),
        .active_pulse_us (a_active_pulse_reg),
        .rest_pulse_us   (a_rest_pulse_reg),
        .phase_next      (phase_a),
        .pulse_us        (pulse_a),
        .busy            (busy_a)
    );

    plas_seq #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_seq_b (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (step),
        .start           (start_b),
        .now_t           (now_t),
        .active_hold_ms  (active_hold_ms_reg),
        .rest_hold_ms    (rest_hold_ms_reg),
        .active_pulse_us (b_active_pulse_reg),
        .rest_pulse_us   (b_rest_pulse_reg),
        .phase_next      (phase_b),
        .pulse_us        (pulse_b),
        .busy            (busy_b)
    );

    always_comb
    begin
        out_data_next = {1'b0, started, evt.level,
                         plas_pkg::phase_code(phase_b), plas_pkg::phase_code(phase_a),
                         pulse_b, pulse_a};

        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_level_reg <= s_axis_tdata[0];
            in_now_reg   <= s_axis_tdata[plas_pkg::NOW_W:1];
        end
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration writes; each register keeps the low bits of the data word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg    <= plas_pkg::DEBOUNCE_RST;
            long_press_ms_reg  <= plas_pkg::LONG_PRESS_RST;
            active_hold_ms_reg <= plas_pkg::ACTIVE_HOLD_RST;
            rest_hold_ms_reg   <= plas_pkg::REST_HOLD_RST;
            a_active_pulse_reg <= plas_pkg::A_ACTIVE_PLS_RST;
            a_rest_pulse_reg   <= plas_pkg::A_REST_PLS_RST;
            b_active_pulse_reg <= plas_pkg::B_ACTIVE_PLS_RST;
            b_rest_pulse_reg   <= plas_pkg::B_REST_PLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (plas_pkg::cfg_idx_t'(cfg_addr))
                plas_pkg::CFG_DEBOUNCE:     debounce_ms_reg    <= cfg_data[plas_pkg::DEB_W-1:0];
                plas_pkg::CFG_LONG_PRESS:   long_press_ms_reg  <= cfg_data[plas_pkg::HOLD_W-1:0];
                plas_pkg::CFG_ACTIVE_HOLD:  active_hold_ms_reg <= cfg_data[plas_pkg::HOLD_W-1:0];
                plas_pkg::CFG_REST_HOLD:    rest_hold_ms_reg   <= cfg_data[plas_pkg::HOLD_W-1:0];
                plas_pkg::CFG_A_ACTIVE_PLS: a_active_pulse_reg <= cfg_data[plas_pkg::PULSE_W-1:0];
                plas_pkg::CFG_A_REST_PLS:   a_rest_pulse_reg   <= cfg_data[plas_pkg::PULSE_W-1:0];
                plas_pkg::CFG_B_ACTIVE_PLS: b_active_pulse_reg <= cfg_data[plas_pkg::PULSE_W-1:0];
                plas_pkg::CFG_B_REST_PLS:   b_rest_pulse_reg   <= cfg_data[plas_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/plas_checker.sv
`include "assert_macros.svh"

// Port-level checks of the press sequencer.
module plas_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [plas_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [plas_pkg::CODE_W-1:0] r_phase_a;
    logic [plas_pkg::CODE_W-1:0] r_phase_b;
    logic [plas_pkg::CODE_W-1:0] r_started;
    logic                        r_level;

    assign r_phase_a = m_axis_tdata[25:24];
    assign r_phase_b = m_axis_tdata[27:26];
    assign r_level   = m_axis_tdata[28];
    assign r_started = m_axis_tdata[30:29];

    // A stalled result item keeps its contents.
    `ASSERT_NEXT(a_out_hold,
                 m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata),
                 "result item changed while stalled")

    // Starting A leaves A busy and B idle.
    `ASSERT_IMPL(a_start_a,
                 m_axis_tvalid && r_started == plas_pkg::START_A,
                 r_phase_a != plas_pkg::PH_CODE_IDLE && r_phase_b == plas_pkg::PH_CODE_IDLE,
                 "start of A with wrong phases")

    // Starting B leaves B busy and A idle.
    `ASSERT_IMPL(a_start_b,
                 m_axis_tvalid && r_started == plas_pkg::START_B,
                 r_phase_b != plas_pkg::PH_CODE_IDLE && r_phase_a == plas_pkg::PH_CODE_IDLE,
                 "start of B with wrong phases")

    // A sequence only starts on a release.
    `ASSERT_IMPL(a_start_rel,
                 m_axis_tvalid && r_started != plas_pkg::START_NONE,
                 r_level,
                 "sequence started while button pressed")

endmodule

bind press_length_actuator_sequencer_unit plas_checker u_plas_checker (.*);

// File: sim/tb_top.sv
module tb_top;

    import plas_pkg::*;

    // One result item as it leaves on m_axis_tdata, highest field first.
    typedef struct packed {
        logic                pad;
        logic [CODE_W-1:0]   started;
        logic                level;
        logic [CODE_W-1:0]   phase_b;
        logic [CODE_W-1:0]   phase_a;
        logic [PULSE_W-1:0]  pulse_b;
        logic [PULSE_W-1:0]  pulse_a;
    } result_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // [0] button_level, [32:1] now_ms, [39:33] zero
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [11:0] pulse_a_us, [23:12] pulse_b_us, [25:24] phase_a, [27:26] phase_b,
    // [28] debounced_level, [30:29] sequence_started, [31] zero
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_addr = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    press_length_actuator_sequencer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the configuration registers, loaded with the
    // power-up values and updated on every register write.
    // ------------------------------------------------------------------
    logic [DEB_W-1:0]    cfg_debounce = DEBOUNCE_RST;
    logic [HOLD_W-1:0]   cfg_long     = LONG_PRESS_RST;
    logic [HOLD_W-1:0]   cfg_active   = ACTIVE_HOLD_RST;
    logic [HOLD_W-1:0]   cfg_rest     = REST_HOLD_RST;
    logic [PULSE_W-1:0]  cfg_a_act    = A_ACTIVE_PLS_RST;
    logic [PULSE_W-1:0]  cfg_a_rest   = A_REST_PLS_RST;
    logic [PULSE_W-1:0]  cfg_b_act    = B_ACTIVE_PLS_RST;
    logic [PULSE_W-1:0]  cfg_b_rest   = B_REST_PLS_RST;

    // Shadow copy of the button and actuator state.
    logic                raw_level_seen = 1'b1;
    logic                level_accepted = 1'b1;
    logic                press_open     = 1'b0;
    logic [NOW_W-1:0]    raw_change_ms  = '0;
    logic [NOW_W-1:0]    press_start_ms = '0;
    logic [CODE_W-1:0]   a_phase        = PH_CODE_IDLE;
    logic [NOW_W-1:0]    a_since_ms     = '0;
    logic [CODE_W-1:0]   b_phase        = PH_CODE_IDLE;
    logic [NOW_W-1:0]    b_since_ms     = '0;

    // Bookkeeping shared by the stimulus, the driver and the monitor.
    logic [IN_TDATA_W-1:0] polls_to_send [$];
    result_t               expected_outputs [$];
    int unsigned           n_polls_queued   = 0;
    int unsigned           n_results_seen   = 0;
    int unsigned           n_errors         = 0;
    int unsigned           n_started_a      = 0;
    int unsigned           n_started_b      = 0;
    int unsigned           n_settings       = 1;
    logic [NOW_W-1:0]      clock_ms         = '0;

    // Traffic shaping: quiet turns off all random idling on both sides, and
    // stall_go starts one long hold-off of the result side.
    logic                  quiet    = 1'b0;
    logic                  stall_go = 1'b0;
    int unsigned           stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Actuator phase step. Only one transition per call, so a zero hold
    // time still spends the entering poll in the new phase's predecessor
    // check exactly once. Returns {phase, start time}.
    // ------------------------------------------------------------------
    function automatic logic [CODE_W+NOW_W-1:0] next_phase(logic [CODE_W-1:0] ph,
                                                          logic [NOW_W-1:0] since,
                                                          logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] held;
        held = now - since;
        if (ph == PH_CODE_ACTIVE && held >= cfg_active)
            return {PH_CODE_REST, now};
        if (ph == PH_CODE_REST && held >= cfg_rest)
            return {PH_CODE_IDLE, since};
        return {ph, since};
    endfunction

    // ------------------------------------------------------------------
    // Predicts the result item of one poll and advances the shadow state.
    // The button logic runs first, then actuator A, then actuator B.
    // ------------------------------------------------------------------
    function automatic result_t next_outputs(logic lvl, logic [NOW_W-1:0] now);
        result_t           r;
        logic [CODE_W-1:0] started;
        logic [NOW_W-1:0]  press_len;
        started = START_NONE;
        if (lvl != raw_level_seen)
        begin
            raw_level_seen = lvl;
            raw_change_ms  = now;
        end
        if (lvl != level_accepted && NOW_W'(now - raw_change_ms) >= {16'd0, cfg_debounce})
        begin
            level_accepted = lvl;
            if (!lvl)
            begin
                press_start_ms = now;
                press_open     = 1'b1;
            end
            else if (press_open)
            begin
                // A release only starts a sequence when both actuators are idle.
                press_len  = now - press_start_ms;
                press_open = 1'b0;
                if (a_phase == PH_CODE_IDLE && b_phase == PH_CODE_IDLE)
                begin
                    if (press_len >= cfg_long)
                    begin
                        b_phase    = PH_CODE_ACTIVE;
                        b_since_ms = now;
                        started    = START_B;
                    end
                    else
                    begin
                        a_phase    = PH_CODE_ACTIVE;
                        a_since_ms = now;
                        started    = START_A;
                    end
                end
            end
        end
        {a_phase, a_since_ms} = next_phase(a_phase, a_since_ms, now);
        {b_phase, b_since_ms} = next_phase(b_phase, b_since_ms, now);

        // An idle actuator drives its rest pulse; pulses follow the live registers.
        r.pulse_a = (a_phase == PH_CODE_ACTIVE) ? cfg_a_act : cfg_a_rest;
        r.pulse_b = (b_phase == PH_CODE_ACTIVE) ? cfg_b_act : cfg_b_rest;
        r.phase_a = a_phase;
        r.phase_b = b_phase;
        r.level   = level_accepted;
        r.started = started;
        r.pad     = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                      n_results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the next queued poll whenever the input side is
    // free, skipping about a third of the cycles unless traffic is quiet.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (polls_to_send.size() > 0 && (quiet || $urandom_range(0, 99) >= 33))
            begin
                s_axis_tdata  <= polls_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Long hold-off of the result side, counted here in cycles.
    always @(posedge clk)
    begin
        if (stall_go)
            stall_left <= 300;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
    end

    // Result side: random back-pressure, none while quiet, none taken during a hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= !(stall_go || stall_left > 0) &&
                             (quiet || $urandom_range(0, 99) >= 33);
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted poll is run through the predictor, and every
    // accepted result item is compared with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_outputs.push_back(next_outputs(s_axis_tdata[0], s_axis_tdata[32:1]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                n_results_seen++;
                if (expected_outputs.size() == 0)
                    report_mismatch($sformatf("unexpected result item %h", m_axis_tdata));
                else
                begin
                    want = expected_outputs.pop_front();
                    if (want.started == START_A)
                        n_started_a++;
                    if (want.started == START_B)
                        n_started_b++;
                    check_field("pulse_a_us", 32'(got.pulse_a), 32'(want.pulse_a));
                    check_field("pulse_b_us", 32'(got.pulse_b), 32'(want.pulse_b));
                    check_field("phase_a", 32'(got.phase_a), 32'(want.phase_a));
                    check_field("phase_b", 32'(got.phase_b), 32'(want.phase_b));
                    check_field("debounced_level", 32'(got.level), 32'(want.level));
                    check_field("sequence_started", 32'(got.started), 32'(want.started));
                    check_field("pad", 32'(got.pad), 32'(want.pad));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_poll(logic lvl, logic [NOW_W-1:0] now);
        polls_to_send.push_back({7'd0, now, lvl});
        n_polls_queued++;
    endtask

    // Holds one raw level while time runs on, ending with a poll at or past dur.
    task automatic hold_level(logic lvl, longint unsigned dur, int unsigned step_max);
        logic [NOW_W-1:0] t0;
        logic [NOW_W-1:0] held;
        t0 = clock_ms;
        forever
        begin
            queue_poll(lvl, clock_ms);
            held = clock_ms - t0;
            if (held >= dur)
                break;
            clock_ms += $urandom_range(0, step_max);
        end
    endtask

    // Waits until every queued poll has come back as a result, then lets the
    // two pipeline stages settle.
    task automatic wait_drained();
        while (n_results_seen != n_polls_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register; it takes effect at the edge where cfg_we is seen high.
    task automatic load_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        case (idx)
            CFG_DEBOUNCE:     cfg_debounce = value[DEB_W-1:0];
            CFG_LONG_PRESS:   cfg_long     = value[HOLD_W-1:0];
            CFG_ACTIVE_HOLD:  cfg_active   = value[HOLD_W-1:0];
            CFG_REST_HOLD:    cfg_rest     = value[HOLD_W-1:0];
            CFG_A_ACTIVE_PLS: cfg_a_act    = value[PULSE_W-1:0];
            CFG_A_REST_PLS:   cfg_a_rest   = value[PULSE_W-1:0];
            CFG_B_ACTIVE_PLS: cfg_b_act    = value[PULSE_W-1:0];
            CFG_B_REST_PLS:   cfg_b_rest   = value[PULSE_W-1:0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Loads a whole setting once the block has nothing in flight. Actuators may
    // still be mid-phase, which checks that pulses follow the new registers.
    task automatic configure(logic [31:0] deb, logic [31:0] long_ms, logic [31:0] act_ms,
                             logic [31:0] rest_ms, logic [31:0] a_act, logic [31:0] a_rest,
                             logic [31:0] b_act, logic [31:0] b_rest);
        wait_drained();
        load_register(CFG_DEBOUNCE, deb);
        load_register(CFG_LONG_PRESS, long_ms);
        load_register(CFG_ACTIVE_HOLD, act_ms);
        load_register(CFG_REST_HOLD, rest_ms);
        load_register(CFG_A_ACTIVE_PLS, a_act);
        load_register(CFG_A_REST_PLS, a_rest);
        load_register(CFG_B_ACTIVE_PLS, b_act);
        load_register(CFG_B_REST_PLS, b_rest);
        n_settings++;
    endtask

    // Queues press/release episodes until the running total reaches target.
    // Most episodes are clean presses of a short or long length, some start
    // with contact bounce, and noise_pct of them are bursts of random polls.
    task automatic run_phase(int unsigned target, int unsigned step_max,
                             longint unsigned cap, int unsigned noise_pct);
        longint unsigned span;
        longint unsigned press_len;
        longint unsigned rel_len;
        logic            bounce_lvl;
        while (n_polls_queued < target)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                repeat ($urandom_range(1, 4))
                    queue_poll(1'($urandom_range(0, 1)),
                               $urandom_range(0, 1) ? $urandom
                                                    : clock_ms + $urandom_range(0, step_max));
            end
            else
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    bounce_lvl = 1'b0;
                    repeat ($urandom_range(1, 4))
                    begin
                        queue_poll(bounce_lvl, clock_ms);
                        bounce_lvl = ~bounce_lvl;
                        clock_ms  += $urandom_range(0, step_max);
                    end
                end
                // Press length: either below the long press time or just past it.
                span = (cfg_long < cap) ? cfg_long : cap;
                if ($urandom_range(0, 1) == 0)
                    press_len = $urandom_range(0, 32'(span));
                else
                    press_len = cfg_long + $urandom_range(0, 4 * step_max);
                press_len += cfg_debounce;
                if (press_len > cap)
                    press_len = cap;
                hold_level(1'b0, press_len, step_max);
                // Release time: sometimes long enough for both hold phases, often not,
                // so that some releases land while an actuator is still busy.
                span = cfg_active + cfg_rest + 2 * step_max;
                if (span > cap)
                    span = cap;
                rel_len = cfg_debounce + $urandom_range(0, 32'(span));
                if (rel_len > cap)
                    rel_len = cap;
                hold_level(1'b1, rel_len, step_max);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned mark;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed polls on the power-up registers: rest pulses after reset,
        // timestamp extremes, contact bounce, a short press starting A, a
        // release while A is busy, both hold phases of A, a long press
        // starting B, and a press that straddles the timestamp wrap.
        queue_poll(1'b1, 32'd0);
        queue_poll(1'b1, 32'hFFFF_FFFF);
        queue_poll(1'b0, 32'd10);
        queue_poll(1'b0, 32'd40);
        queue_poll(1'b1, 32'd45);
        queue_poll(1'b0, 32'd50);
        queue_poll(1'b0, 32'd100);
        queue_poll(1'b1, 32'd300);
        queue_poll(1'b1, 32'd350);
        queue_poll(1'b0, 32'd360);
        queue_poll(1'b0, 32'd410);
        queue_poll(1'b1, 32'd420);
        queue_poll(1'b1, 32'd470);
        queue_poll(1'b1, 32'd1350);
        queue_poll(1'b1, 32'd2350);
        queue_poll(1'b0, 32'd2400);
        queue_poll(1'b0, 32'd2450);
        queue_poll(1'b0, 32'd7450);
        queue_poll(1'b1, 32'd7460);
        queue_poll(1'b1, 32'd7510);
        queue_poll(1'b1, 32'd8510);
        queue_poll(1'b1, 32'd9510);
        queue_poll(1'b0, 32'hFFFF_FFF0);
        queue_poll(1'b0, 32'h0000_0022);
        queue_poll(1'b1, 32'h0000_0030);
        queue_poll(1'b1, 32'h0000_0062);

        // Short times so that many full sequences fit. Halfway through, the
        // sender stops until every result is back.
        configure(4, 60, 25, 20, $urandom_range(0, 3000), $urandom_range(0, 3000),
                  $urandom_range(0, 3000), $urandom_range(0, 3000));
        clock_ms = 32'd1000;
        run_phase(240, 6, 200, 10);
        wait_drained();
        run_phase(450, 6, 200, 10);

        // All zero times: every press counts as long and phases end at once.
        // Pulse registers at both extremes, one written with all ones to check
        // that the upper data bits are dropped. No idling on either side.
        configure(0, 0, 0, 0, 32'd0, 32'hFFFF_FFFF, 32'd4095, 32'd0);
        @(posedge clk);
        quiet <= 1'b1;
        run_phase(750, 3, 40, 15);

        // Largest times, with timestamps running across the wrap.
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'd3000, 32'd3000, 32'd3000, 32'd3000);
        quiet <= 1'b0;
        clock_ms = 32'hFFFF_0000 + $urandom_range(0, 32'hFFFF);
        run_phase(950, 30000, 400000, 40);

        // Middle values. Once the block is busy, the result side holds off for
        // a long stretch while polls keep coming, so the input side stalls.
        configure(10, 150, 40, 60, $urandom_range(0, 3000), $urandom_range(0, 3000),
                  $urandom_range(0, 3000), $urandom_range(0, 3000));
        mark = n_polls_queued;
        run_phase(1450, 12, 400, 15);
        while (n_results_seen < mark + 100)
            @(posedge clk);
        @(posedge clk);
        stall_go <= 1'b1;
        @(posedge clk);
        stall_go <= 1'b0;

        // Tiny times with steps of at most two milliseconds, which hit the exact
        // threshold of every comparison.
        configure(1, 8, 3, 5, $urandom_range(0, 3000), $urandom_range(0, 3000),
                  $urandom_range(0, 3000), $urandom_range(0, 3000));
        clock_ms = $urandom;
        run_phase(1950, 2, 30, 10);

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Run covered %0d polls over %0d register settings, %0d results checked.",
                 n_polls_queued, n_settings, n_results_seen);
        $display("Sequences started: %0d on actuator A, %0d on actuator B; %0d mismatches.",
                 n_started_a, n_started_b, n_errors);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of the sequence above.
    initial
    begin
        #2000000;
        $display("Timeout with %0d of %0d results received.", n_results_seen, n_polls_queued);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
